// ===== sv/stereo_rms_level_meter_macros.svh =====
// ----------------------------------------------------------------------------
// Stereo RMS level meter: assertion macros
// Shorthand for the clocked, reset-qualified checks of the level meter checker.
// ----------------------------------------------------------------------------
`ifndef STEREO_RMS_LEVEL_METER_MACROS_SVH
`define STEREO_RMS_LEVEL_METER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define SRLM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("level meter check failed");

// Consequent checked in the cycle after the antecedent.
`define SRLM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("level meter check failed");

`endif

// ===== sv/srlm_pkg.sv =====
// ----------------------------------------------------------------------------
// Stereo RMS level meter package
// Sequencer states, register indexes, reset values and fixed datapath widths.
// ----------------------------------------------------------------------------
package srlm_pkg;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ_L,
        S_SQ_R,
        S_DIV_MEAN,
        S_SQRT,
        S_MUL_OLD,
        S_MUL_NEW,
        S_DIV_SCALE,
        S_EMIT
    } t_state;

    // Configuration register indexes
    typedef logic [0:0] t_cfg_index;
    localparam t_cfg_index CFG_SMOOTH_GAIN = 1'd0;
    localparam t_cfg_index CFG_FULL_SCALE  = 1'd1;

    localparam int GAIN_W = 16;
    localparam int FS_W   = 15;
    localparam int CFG_W  = 16;

    localparam logic [GAIN_W-1:0] GAIN_RESET       = 16'd4588;
    localparam logic [FS_W-1:0]   FULL_SCALE_RESET = 15'd5571;

    // Shared serial multiplier: 24-bit multiplicand, 17-bit multiplier
    localparam int MUL_AW = 24;
    localparam int MUL_BW = 17;
    localparam int PROD_W = MUL_AW + MUL_BW;

    // Leaky average, Q1.23, and its 42-bit accumulator
    localparam int AVG_W = 24;
    localparam int ACC_W = 42;

    // Square root: 30-bit radicand, two bits per step
    localparam int SQ_IN_W   = 30;
    localparam int ROOT_W    = 15;
    localparam int SQ_STEPS  = SQ_IN_W / 2;
    localparam int SQ_STEP_W = $clog2(SQ_STEPS);

    localparam int SMOOTH_W = 17;
    localparam int SCALED_W = 16;

    localparam logic [SCALED_W-1:0] SCALED_ONE = 16'd32768;
    localparam logic [ROOT_W-1:0]   RMS_MAX    = 15'd16384;

endpackage

// ===== sv/srlm_mul.sv =====
// ----------------------------------------------------------------------------
// Level meter serial multiplier
// Unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module srlm_mul #(
    parameter int AW = 24,
    parameter int BW = 17
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [AW-1:0]    i_a,
    input  logic [BW-1:0]    i_b,
    output logic             o_done,
    output logic [AW+BW-1:0] o_prod
);

    localparam int CW = $clog2(BW + 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [AW-1:0]    r_a;
    logic [AW+BW-1:0] r_p;
    logic [AW:0]      w_sum;

    // high half plus multiplicand when the low bit is set
    assign w_sum = {1'b0, r_p[AW+BW-1:BW]} + (r_p[0] ? {1'b0, r_a} : {(AW + 1){1'b0}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(BW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_p <= {{AW{1'b0}}, i_b};
        end else if (r_busy) begin
            r_p <= {w_sum, r_p[BW-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_p;

endmodule

// ===== sv/srlm_div.sv =====
// ----------------------------------------------------------------------------
// Level meter serial divider
// Restoring divider, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module srlm_div #(
    parameter int NW = 37,
    parameter int DW = 15
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_done,
    output logic [NW-1:0] o_quot
);

    localparam int CW = $clog2(NW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_q;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_d;
    logic [DW:0]   w_t;
    logic [DW:0]   w_diff;
    logic          w_ge;

    // partial remainder with the next dividend bit shifted in
    assign w_t    = {r_rem, r_q[NW-1]};
    assign w_ge   = (w_t >= {1'b0, r_d});
    assign w_diff = w_t - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[NW-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DW-1:0] : w_t[DW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== sv/stereo_rms_level_meter.sv =====
// ----------------------------------------------------------------------------
// Stereo RMS level meter
// Buffer RMS of a stereo Q1.15 stream with leaky smoothing and full-scale scaling.
// ----------------------------------------------------------------------------
// Each accepted frame runs two squares, left then right, through the
// bit-serial multiplier, each with its launch and done. A frame that closes a
// buffer (marked last, or the MAX_FRAMES-th) then runs the buffer close
// sequence: the mean divide, the square root, two multiplies for the leaky
// average, the full-scale divide and the emit state. The result sits in an
// output register, so the next frame is taken while it waits; only a second
// buffer close stalls in the emit state until the first result is
// transferred. Configuration writes are registered directly and are meant
// for idle periods. The sample field is trimmed to SAMPLE_BITS (capped at 16)
// and left aligned to Q1.15 before squaring.
// ----------------------------------------------------------------------------
module stereo_rms_level_meter #(
    parameter int MAX_FRAMES  = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration write port
    input  logic                        i_cfg_wr_en,
    input  srlm_pkg::t_cfg_index        i_cfg_index,
    input  logic [srlm_pkg::CFG_W-1:0]  i_cfg_data,
    // frame input
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic signed [15:0]          i_left_sample,
    input  logic signed [15:0]          i_right_sample,
    input  logic                        i_last_frame,
    // buffer result
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [14:0]                 o_rms_level,
    output logic [14:0]                 o_smoothed_level,
    output logic [15:0]                 o_scaled_level,
    output logic [15:0]                 o_buffers_seen
);

    // effective sample width and left-align shift
    localparam int EFF_BITS     = (SAMPLE_BITS > 16) ? 16 : ((SAMPLE_BITS < 1) ? 1 : SAMPLE_BITS);
    localparam int SAMPLE_SHIFT = 16 - EFF_BITS;
    // frame counter holds 0..MAX_FRAMES
    localparam int NBW          = $clog2(MAX_FRAMES + 1);
    // sum of up to 2*MAX_FRAMES squares, each at most 2^28
    localparam int SUM_W        = 29 + $clog2(2 * MAX_FRAMES);
    // one divider serves both the mean and the full-scale ratio
    localparam int DIV_NW       = (SUM_W - 1 > 32) ? SUM_W - 1 : 32;
    localparam int DIV_DW       = (NBW > srlm_pkg::FS_W) ? NBW : srlm_pkg::FS_W;

    // ---------------- state ----------------
    srlm_pkg::t_state r_state;
    srlm_pkg::t_state n_state;

    logic [srlm_pkg::GAIN_W-1:0]  r_gain;
    logic [srlm_pkg::FS_W-1:0]    r_full_scale;

    logic [SUM_W-1:0]             r_sum;
    logic [NBW-1:0]               r_frames;
    logic [srlm_pkg::AVG_W-1:0]   r_avg;
    logic [15:0]                  r_tally;

    logic                         r_mul_start;
    logic                         n_mul_start;
    logic                         r_div_start;
    logic                         n_div_start;
    logic [srlm_pkg::SQ_STEP_W-1:0] r_sq_step;

    // payload registers
    logic [15:0]                  r_mag_l;
    logic [15:0]                  r_mag_r;
    logic                         r_last;
    logic [srlm_pkg::ACC_W-1:0]   r_acc;
    logic [srlm_pkg::SQ_IN_W-1:0] r_rad;
    logic [srlm_pkg::ROOT_W-1:0]  r_root;
    logic [srlm_pkg::ROOT_W:0]    r_srem;
    logic [srlm_pkg::SCALED_W-1:0] r_scaled;

    logic                         r_out_valid;
    logic [14:0]                  r_out_rms;
    logic [14:0]                  r_out_smoothed;
    logic [15:0]                  r_out_scaled;
    logic [15:0]                  r_out_tally;

    // ---------------- combinational ----------------
    logic                         w_in_ready;
    logic                         w_load_out;
    logic                         w_accept;

    logic signed [15:0]           w_left_s;
    logic signed [15:0]           w_right_s;
    logic [15:0]                  w_left_mag;
    logic [15:0]                  w_right_mag;

    logic [NBW-1:0]               w_frames_inc;
    logic                         w_buf_end;
    logic [SUM_W-1:0]             w_sum_next;

    logic [srlm_pkg::MUL_AW-1:0]  w_mul_a;
    logic [srlm_pkg::MUL_BW-1:0]  w_mul_b;
    logic                         w_mul_done;
    logic [srlm_pkg::PROD_W-1:0]  w_prod;

    logic [DIV_NW-1:0]            w_div_num;
    logic [DIV_DW-1:0]            w_div_den;
    logic                         w_div_done;
    logic [DIV_NW-1:0]            w_quot;

    logic [srlm_pkg::FS_W-1:0]    w_fs;
    logic [srlm_pkg::AVG_W:0]     w_smooth_sum;
    logic [srlm_pkg::SMOOTH_W-1:0] w_smoothed;
    logic [srlm_pkg::ACC_W-1:0]   w_acc_sum;

    // square root step: bring down two radicand bits, try 4*root+1
    logic [srlm_pkg::ROOT_W+1:0]  w_sq_t;
    logic [srlm_pkg::ROOT_W+1:0]  w_sq_trial;
    logic [srlm_pkg::ROOT_W+1:0]  w_sq_diff;
    logic                         w_sq_ge;

    assign w_accept = i_in_valid && w_in_ready;

    // trim to SAMPLE_BITS and left align into Q1.15
    assign w_left_s    = i_left_sample <<< SAMPLE_SHIFT;
    assign w_right_s   = i_right_sample <<< SAMPLE_SHIFT;
    assign w_left_mag  = w_left_s[15] ? 16'(-w_left_s) : w_left_s;
    assign w_right_mag = w_right_s[15] ? 16'(-w_right_s) : w_right_s;

    // square / 4 of the finished product added to the running sum
    assign w_sum_next   = r_sum + SUM_W'(w_prod[30:2]);
    assign w_frames_inc = r_frames + 1'b1;
    assign w_buf_end    = r_last || (w_frames_inc == NBW'(MAX_FRAMES));

    assign w_fs         = (r_full_scale == '0) ? srlm_pkg::FS_W'(1) : r_full_scale;
    assign w_smooth_sum = {1'b0, r_avg} + (srlm_pkg::AVG_W + 1)'(128);
    assign w_smoothed   = w_smooth_sum[srlm_pkg::AVG_W:8];
    assign w_acc_sum    = r_acc + srlm_pkg::ACC_W'(w_prod);

    assign w_sq_t     = {r_srem[srlm_pkg::ROOT_W-1:0],
                         r_rad[srlm_pkg::SQ_IN_W-1:srlm_pkg::SQ_IN_W-2]};
    assign w_sq_trial = {r_root, 2'b01};
    assign w_sq_ge    = (w_sq_t >= w_sq_trial);
    assign w_sq_diff  = w_sq_t - w_sq_trial;

    // multiplier operands by phase
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            srlm_pkg::S_SQ_L: begin
                w_mul_a = srlm_pkg::MUL_AW'(r_mag_l);
                w_mul_b = srlm_pkg::MUL_BW'(r_mag_l);
            end
            srlm_pkg::S_SQ_R: begin
                w_mul_a = srlm_pkg::MUL_AW'(r_mag_r);
                w_mul_b = srlm_pkg::MUL_BW'(r_mag_r);
            end
            srlm_pkg::S_MUL_OLD: begin
                // (1 - g) * old average
                w_mul_a = r_avg;
                w_mul_b = 17'h10000 - srlm_pkg::MUL_BW'(r_gain);
            end
            srlm_pkg::S_MUL_NEW: begin
                // g * rms in Q1.23
                w_mul_a = srlm_pkg::MUL_AW'({r_root, 8'b0});
                w_mul_b = srlm_pkg::MUL_BW'(r_gain);
            end
            default: begin
            end
        endcase
    end

    // divider operands: mean = (sum/2)/n, otherwise smoothed * 2^15 / full scale
    always_comb begin
        if (r_state == srlm_pkg::S_DIV_MEAN) begin
            w_div_num = DIV_NW'(r_sum[SUM_W-1:1]);
            w_div_den = DIV_DW'(r_frames);
        end else begin
            w_div_num = DIV_NW'({w_smoothed, 15'b0});
            w_div_den = DIV_DW'(w_fs);
        end
    end

    srlm_mul #(
        .AW (srlm_pkg::MUL_AW),
        .BW (srlm_pkg::MUL_BW)
    ) u_srlm_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    srlm_div #(
        .NW (DIV_NW),
        .DW (DIV_DW)
    ) u_srlm_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (w_div_num),
        .i_divisor  (w_div_den),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= srlm_pkg::S_IDLE;
            r_mul_start <= 1'b0;
            r_div_start <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mul_start <= n_mul_start;
            r_div_start <= n_div_start;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_mul_start = 1'b0;
        n_div_start = 1'b0;
        w_in_ready  = 1'b0;
        w_load_out  = 1'b0;
        unique case (r_state)
            srlm_pkg::S_IDLE: begin
                w_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state     = srlm_pkg::S_SQ_L;
                    n_mul_start = 1'b1;
                end
            end
            srlm_pkg::S_SQ_L: begin
                if (w_mul_done) begin
                    n_state     = srlm_pkg::S_SQ_R;
                    n_mul_start = 1'b1;
                end
            end
            srlm_pkg::S_SQ_R: begin
                if (w_mul_done) begin
                    if (w_buf_end) begin
                        n_state     = srlm_pkg::S_DIV_MEAN;
                        n_div_start = 1'b1;
                    end else begin
                        n_state = srlm_pkg::S_IDLE;
                    end
                end
            end
            srlm_pkg::S_DIV_MEAN: begin
                if (w_div_done) begin
                    n_state = srlm_pkg::S_SQRT;
                end
            end
            srlm_pkg::S_SQRT: begin
                if (r_sq_step == srlm_pkg::SQ_STEP_W'(srlm_pkg::SQ_STEPS - 1)) begin
                    n_state     = srlm_pkg::S_MUL_OLD;
                    n_mul_start = 1'b1;
                end
            end
            srlm_pkg::S_MUL_OLD: begin
                if (w_mul_done) begin
                    n_state     = srlm_pkg::S_MUL_NEW;
                    n_mul_start = 1'b1;
                end
            end
            srlm_pkg::S_MUL_NEW: begin
                if (w_mul_done) begin
                    n_state     = srlm_pkg::S_DIV_SCALE;
                    n_div_start = 1'b1;
                end
            end
            srlm_pkg::S_DIV_SCALE: begin
                if (w_div_done) begin
                    n_state = srlm_pkg::S_EMIT;
                end
            end
            srlm_pkg::S_EMIT: begin
                // wait for the output register to free up
                if (!r_out_valid || i_out_ready) begin
                    w_load_out = 1'b1;
                    n_state    = srlm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = srlm_pkg::S_IDLE;
            end
        endcase
    end

    // ---------------- control and state registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain       <= srlm_pkg::GAIN_RESET;
            r_full_scale <= srlm_pkg::FULL_SCALE_RESET;
            r_sum        <= '0;
            r_frames     <= '0;
            r_avg        <= '0;
            r_tally      <= '0;
            r_sq_step    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    srlm_pkg::CFG_SMOOTH_GAIN: r_gain       <= i_cfg_data[srlm_pkg::GAIN_W-1:0];
                    srlm_pkg::CFG_FULL_SCALE:  r_full_scale <= i_cfg_data[srlm_pkg::FS_W-1:0];
                    default: begin
                    end
                endcase
            end

            // square accumulation; the buffer closes after the mean is taken
            if (w_mul_done && (r_state == srlm_pkg::S_SQ_L)) begin
                r_sum <= w_sum_next;
            end
            if (w_mul_done && (r_state == srlm_pkg::S_SQ_R)) begin
                r_sum    <= w_sum_next;
                r_frames <= w_frames_inc;
            end
            if (w_div_done && (r_state == srlm_pkg::S_DIV_MEAN)) begin
                r_sum     <= '0;
                r_frames  <= '0;
                r_sq_step <= '0;
            end

            if (r_state == srlm_pkg::S_SQRT) begin
                r_sq_step <= r_sq_step + 1'b1;
            end

            if (w_mul_done && (r_state == srlm_pkg::S_MUL_NEW)) begin
                r_avg <= w_acc_sum[srlm_pkg::AVG_W+15:16];
            end

            if (w_load_out) begin
                r_tally     <= r_tally + 1'b1;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mag_l <= w_left_mag;
            r_mag_r <= w_right_mag;
            r_last  <= i_last_frame;
        end

        if (w_div_done && (r_state == srlm_pkg::S_DIV_MEAN)) begin
            r_rad  <= w_quot[srlm_pkg::SQ_IN_W-1:0];
            r_root <= '0;
            r_srem <= '0;
        end else if (r_state == srlm_pkg::S_SQRT) begin
            r_rad  <= {r_rad[srlm_pkg::SQ_IN_W-3:0], 2'b00};
            r_root <= {r_root[srlm_pkg::ROOT_W-2:0], w_sq_ge};
            r_srem <= w_sq_ge ? w_sq_diff[srlm_pkg::ROOT_W:0] : w_sq_t[srlm_pkg::ROOT_W:0];
        end

        // old-average product plus the rounding half
        if (w_mul_done && (r_state == srlm_pkg::S_MUL_OLD)) begin
            r_acc <= srlm_pkg::ACC_W'(w_prod) + srlm_pkg::ACC_W'(32768);
        end

        // ratio clamped at 1.0
        if (w_div_done && (r_state == srlm_pkg::S_DIV_SCALE)) begin
            r_scaled <= (w_quot > DIV_NW'(srlm_pkg::SCALED_ONE))
                      ? srlm_pkg::SCALED_ONE : w_quot[srlm_pkg::SCALED_W-1:0];
        end

        if (w_load_out) begin
            r_out_rms      <= r_root[14:0];
            r_out_smoothed <= w_smoothed[14:0];
            r_out_scaled   <= r_scaled;
            r_out_tally    <= r_tally + 1'b1;
        end
    end

    assign o_in_ready       = w_in_ready;
    assign o_out_valid      = r_out_valid;
    assign o_rms_level      = r_out_rms;
    assign o_smoothed_level = r_out_smoothed;
    assign o_scaled_level   = r_out_scaled;
    assign o_buffers_seen   = r_out_tally;

endmodule

// ===== sv/srlm_checker.sv =====
// ----------------------------------------------------------------------------
// Stereo RMS level meter checker
// Port-level checks of the level meter, bound to the top level.
// ----------------------------------------------------------------------------
`include "stereo_rms_level_meter_macros.svh"

module srlm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [14:0] o_rms_level,
    input logic [14:0] o_smoothed_level,
    input logic [15:0] o_scaled_level,
    input logic [15:0] o_buffers_seen
);

    // held result stays put until transferred
    `SRLM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_rms_level) && $stable(o_smoothed_level) && $stable(o_scaled_level) && $stable(o_buffers_seen))

    // a frame transfer keeps the input side busy for the squaring
    `SRLM_ASSERT_NEXT(a_busy_after_in, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

    // a new result only comes out of a buffer close
    `SRLM_ASSERT_SAME(a_result_from_close, i_clk, i_rst_n, $rose(o_out_valid), $past(!o_in_ready) && o_in_ready)

    // levels stay within their ranges
    `SRLM_ASSERT_SAME(a_level_range, i_clk, i_rst_n, o_out_valid, (o_scaled_level <= srlm_pkg::SCALED_ONE) && (o_rms_level <= srlm_pkg::RMS_MAX))

endmodule

bind stereo_rms_level_meter srlm_checker u_srlm_checker (.*);

// ===== tb/stereo_rms_level_meter_tb.sv =====
// ----------------------------------------------------------------------------
// Stereo RMS level meter testbench
// Drives stereo frames through the valid/ready input, programs the gain and
// full-scale registers while the meter is idle, and checks every buffer
// result against a cycle-free model of the RMS, leaky average and scaling.
// ----------------------------------------------------------------------------
module stereo_rms_level_meter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_LIMIT  = 256;      // MAX_FRAMES of the instance
    localparam int SETTLE_WAIT  = 250;      // covers a frame plus a buffer close, with margin
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int RANDOM_ITEMS = 350;

    // one buffer result as it leaves the meter
    typedef struct packed {
        logic [14:0] rms;
        logic [14:0] smoothed;
        logic [15:0] scaled;
        logic [15:0] seen;
    } t_level_result;

    // DUT ports
    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_wr_en;
    srlm_pkg::t_cfg_index           i_cfg_index;
    logic [srlm_pkg::CFG_W-1:0]     i_cfg_data;
    logic                           i_in_valid;
    logic                           o_in_ready;
    logic signed [15:0]             i_left_sample;
    logic signed [15:0]             i_right_sample;
    logic                           i_last_frame;
    logic                           o_out_valid;
    logic                           i_out_ready;
    logic [14:0]                    o_rms_level;
    logic [14:0]                    o_smoothed_level;
    logic [15:0]                    o_scaled_level;
    logic [15:0]                    o_buffers_seen;

    // meter model state
    logic [srlm_pkg::GAIN_W-1:0]    gain_reg;
    logic [srlm_pkg::FS_W-1:0]      full_scale_reg;
    longint unsigned                square_acc;
    int                             frame_cnt;
    logic [srlm_pkg::AVG_W-1:0]     level_avg;
    logic [15:0]                    tally;

    // buffer results still to come out, oldest first
    t_level_result                  pending_levels[$];

    int                             fail_count;
    int                             cycle_count;
    int                             frames_sent;
    bit                             in_idle_en;     // random gaps between input transfers
    bit                             out_idle_en;    // random ready drops on the result side
    int                             hold_request;   // long receiver hold-off, in cycles
    int                             out_stall_left;

    stereo_rms_level_meter #(
        .MAX_FRAMES  (FRAME_LIMIT),
        .SAMPLE_BITS (16)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_left_sample    (i_left_sample),
        .i_right_sample   (i_right_sample),
        .i_last_frame     (i_last_frame),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_rms_level      (o_rms_level),
        .o_smoothed_level (o_smoothed_level),
        .o_scaled_level   (o_scaled_level),
        .o_buffers_seen   (o_buffers_seen)
    );

    // 20 ns clock
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run here
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[stereo_rms_level_meter] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------

    // Bitwise integer square root, two radicand bits per step
    function automatic logic [14:0] int_sqrt(input int unsigned x);
        int unsigned root;
        int unsigned probe;
        root  = 0;
        probe = 32'd1 << 30;
        while (probe > x) probe = probe >> 2;
        while (probe != 0) begin
            if (x >= root + probe) begin
                x    = x - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root[14:0];
    endfunction

    // Fold one accepted frame into the model; queue a result when the buffer closes.
    // SAMPLE_BITS is 16 here, so the sample field is already Q1.15.
    task automatic fold_frame(input logic signed [15:0] left, input logic signed [15:0] right,
                              input logic last);
        int              ls;
        int              rs;
        int unsigned     mean;
        logic [14:0]     root;
        longint unsigned acc;
        int unsigned     smooth;
        longint unsigned scaled;
        int unsigned     fs_eff;
        t_level_result   res;
        ls = left;
        rs = right;
        // halved-sample squares: (s*s) >> 2, at most 2^28 per channel
        square_acc = square_acc + 64'((ls * ls) >> 2) + 64'((rs * rs) >> 2);
        frame_cnt  = frame_cnt + 1;
        if (!last && frame_cnt < FRAME_LIMIT) return;

        mean = int'(square_acc / (64'd2 * 64'(frame_cnt)));
        root = int_sqrt(mean);

        // leaky average in Q1.23, rounded back from the Q0.16 weights
        acc = (64'd65536 - 64'(gain_reg)) * 64'(level_avg)
            + 64'(gain_reg) * (64'(root) << 8) + 64'd32768;
        level_avg = acc[16 +: srlm_pkg::AVG_W];

        smooth = (32'(level_avg) + 32'd128) >> 8;
        fs_eff = (full_scale_reg == '0) ? 32'd1 : 32'(full_scale_reg);
        scaled = (64'(smooth) << 15) / 64'(fs_eff);
        if (scaled > 64'd32768) scaled = 64'd32768;

        tally      = tally + 16'd1;
        square_acc = 0;
        frame_cnt  = 0;

        res.rms      = root;
        res.smoothed = smooth[14:0];
        res.scaled   = scaled[15:0];
        res.seen     = tally;
        pending_levels.insert(pending_levels.size(), res);
    endtask

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap(input bit enable);
        int roll;
        if (!enable) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 4);
        return $urandom_range(10, 80);
    endfunction

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Ready driver: random drops, plus the long hold-off asked for by a test.
    // The hold-off is counted down here, once per falling edge.
    initial begin
        i_out_ready    = 1'b0;
        out_stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                out_stall_left = hold_request;
                hold_request   = 0;
            end
            if (out_stall_left > 0) begin
                i_out_ready    <= 1'b0;
                out_stall_left  = out_stall_left - 1;
            end else if (out_idle_en && $urandom_range(0, 4) == 0) begin
                i_out_ready    <= 1'b0;
                out_stall_left  = pick_gap(1'b1);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Result checker: each result transfer against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_levels.size() == 0) begin
                $error("unexpected result: rms %0d smoothed %0d scaled %0d seen %0d",
                       o_rms_level, o_smoothed_level, o_scaled_level, o_buffers_seen);
                fail_count = fail_count + 1;
            end else begin
                t_level_result want;
                want = pending_levels.pop_front();
                if (o_rms_level !== want.rms) begin
                    $error("rms_level: expected %0d, actual %0d", want.rms, o_rms_level);
                    fail_count = fail_count + 1;
                end
                if (o_smoothed_level !== want.smoothed) begin
                    $error("smoothed_level: expected %0d, actual %0d",
                           want.smoothed, o_smoothed_level);
                    fail_count = fail_count + 1;
                end
                if (o_scaled_level !== want.scaled) begin
                    $error("scaled_level: expected %0d, actual %0d",
                           want.scaled, o_scaled_level);
                    fail_count = fail_count + 1;
                end
                if (o_buffers_seen !== want.seen) begin
                    $error("buffers_seen: expected %0d, actual %0d",
                           want.seen, o_buffers_seen);
                    fail_count = fail_count + 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Sample classes: full range, near zero, the rails, loud
    function automatic logic signed [15:0] pick_sample(input int mode);
        logic signed [15:0] s;
        case (mode)
            0: s = 16'($urandom);
            1: s = 16'(int'($urandom_range(0, 511)) - 256);
            2: begin
                case ($urandom_range(0, 4))
                    0: s = 16'sh7FFF;
                    1: s = 16'sh8000;
                    2: s = 16'sh0000;
                    3: s = 16'shFFFF;
                    default: s = 16'sh0001;
                endcase
            end
            default: begin
                s = 16'($urandom_range(16384, 32767));
                if ($urandom_range(0, 1) == 1) s = -s;
            end
        endcase
        return s;
    endfunction

    // One frame transfer. Valid stays up when the next frame follows at once.
    task automatic send_frame(input logic signed [15:0] left, input logic signed [15:0] right,
                              input logic last, input int gap);
        @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_left_sample  <= left;
        i_right_sample <= right;
        i_last_frame   <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        fold_frame(left, right, last);
        frames_sent = frames_sent + 1;
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // A buffer of len frames; past FRAME_LIMIT the meter closes it on its own
    task automatic send_buffer(input int len, input int mode);
        for (int i = 0; i < len; i++)
            send_frame(pick_sample(mode), pick_sample(mode), i == len - 1, pick_gap(in_idle_en));
    endtask

    // Drain: all results out, then let an in-flight frame finish
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_levels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    // Register write; only called while the meter is idle
    task automatic write_cfg(input srlm_pkg::t_cfg_index idx,
                             input logic [srlm_pkg::CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == srlm_pkg::CFG_SMOOTH_GAIN) gain_reg = data[srlm_pkg::GAIN_W-1:0];
        else                                  full_scale_reg = data[srlm_pkg::FS_W-1:0];
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset-value registers; single-frame buffers at the rails and at zero, then one four-frame buffer
    task automatic test_reset_defaults();
        in_idle_en  = 1'b1;
        out_idle_en = 1'b1;
        send_frame(16'sh7FFF, 16'sh7FFF, 1'b1, pick_gap(1'b1));
        send_frame(16'sh8000, 16'sh8000, 1'b1, pick_gap(1'b1));   // largest RMS
        send_frame(16'sh0000, 16'sh0000, 1'b1, pick_gap(1'b1));
        send_frame(16'sh7FFF, 16'sh8000, 1'b1, pick_gap(1'b1));
        send_frame(16'shFFFF, 16'sh0001, 1'b1, pick_gap(1'b1));
        send_frame(16'sh8000, 16'sh0000, 1'b0, 0);
        send_frame(16'sh0000, 16'sh7FFF, 1'b0, 0);
        send_frame(16'sh5555, 16'shAAAA, 1'b0, 0);
        send_frame(16'shAAAA, 16'sh5555, 1'b1, pick_gap(1'b1));
        wait_idle();
    endtask

    // Gain 0 freezes the average; gain 65535 nearly follows the RMS
    task automatic test_gain_extremes();
        write_cfg(srlm_pkg::CFG_SMOOTH_GAIN, 16'd0);
        send_frame(16'sh8000, 16'sh8000, 1'b1, 0);
        send_frame(16'sh0000, 16'sh0000, 1'b1, 0);
        wait_idle();
        write_cfg(srlm_pkg::CFG_SMOOTH_GAIN, 16'hFFFF);
        send_frame(16'sh8000, 16'sh7FFF, 1'b1, 0);
        send_frame(16'sh1234, 16'shEDCB, 1'b1, 0);
        send_frame(16'sh0000, 16'sh0000, 1'b1, 0);
        send_frame(16'sh8000, 16'sh8000, 1'b1, 0);
        wait_idle();
    endtask

    // Full scale at 1 (clamps), at its top, and zero (treated as 1)
    task automatic test_full_scale_extremes();
        write_cfg(srlm_pkg::CFG_FULL_SCALE, 16'd1);
        send_frame(16'sh0100, 16'shFF00, 1'b1, 0);
        wait_idle();
        write_cfg(srlm_pkg::CFG_FULL_SCALE, 16'd32767);
        send_frame(16'sh8000, 16'sh8000, 1'b1, 0);
        send_frame(16'sh4000, 16'shC000, 1'b1, 0);
        wait_idle();
        write_cfg(srlm_pkg::CFG_FULL_SCALE, 16'd0);
        send_frame(16'sh2000, 16'sh2000, 1'b1, 0);
        wait_idle();
        // bit 15 lies outside the register: this is full scale 0 again
        write_cfg(srlm_pkg::CFG_FULL_SCALE, 16'h8000);
        send_frame(16'sh0001, 16'sh0000, 1'b1, 0);
        wait_idle();
        write_cfg(srlm_pkg::CFG_SMOOTH_GAIN, 16'(srlm_pkg::GAIN_RESET));
        write_cfg(srlm_pkg::CFG_FULL_SCALE, 16'(srlm_pkg::FULL_SCALE_RESET));
    endtask

    // Unmarked frames: the FRAME_LIMIT-th closes the buffer by itself, and the
    // run carries on into a new buffer that its marked frame closes
    task automatic test_buffer_full();
        in_idle_en  = 1'b0;
        out_idle_en = 1'b1;
        send_buffer(FRAME_LIMIT + 40, 3);
        wait_idle();
    endtask

    // Receiver holds off for a long stretch while short buffers keep coming:
    // the output register fills, the second close stalls, input ready drops.
    task automatic test_backpressure();
        in_idle_en   = 1'b0;
        out_idle_en  = 1'b0;
        hold_request = 3000;
        for (int i = 0; i < 24; i++)
            send_frame(pick_sample(0), pick_sample(2), i[0], 0);
        wait_idle();
    endtask

    // Random buffers under random registers, several register settings
    task automatic test_random_traffic();
        int start;
        int roll;
        int len;
        for (int phase = 0; phase < 5; phase++) begin
            in_idle_en  = (phase != 2);
            out_idle_en = (phase != 2);
            roll = $urandom_range(0, 9);
            write_cfg(srlm_pkg::CFG_SMOOTH_GAIN, (roll == 0) ? 16'd0 :
                                                 (roll == 1) ? 16'hFFFF : 16'($urandom));
            roll = $urandom_range(0, 9);
            write_cfg(srlm_pkg::CFG_FULL_SCALE, (roll == 0) ? 16'd1 :
                                                (roll == 1) ? 16'd32767 :
                                                (roll == 2) ? 16'($urandom) :
                                                              16'($urandom_range(1, 32767)));
            start = frames_sent;
            while (frames_sent - start < RANDOM_ITEMS / 5) begin
                roll = $urandom_range(0, 99);
                if (roll < 85)      len = $urandom_range(1, 16);
                else if (roll < 97) len = $urandom_range(17, 64);
                else                len = $urandom_range(200, 300);
                send_buffer(len, $urandom_range(0, 3));
            end
            wait_idle();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        // every input known from time zero
        i_rst_n        = 1'b0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_index    = srlm_pkg::CFG_SMOOTH_GAIN;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_left_sample  = '0;
        i_right_sample = '0;
        i_last_frame   = 1'b0;
        hold_request   = 0;
        in_idle_en     = 1'b0;
        out_idle_en    = 1'b0;
        fail_count     = 0;
        frames_sent    = 0;

        // model state after reset
        gain_reg       = srlm_pkg::GAIN_RESET;
        full_scale_reg = srlm_pkg::FULL_SCALE_RESET;
        square_acc     = 0;
        frame_cnt      = 0;
        level_avg      = '0;
        tally          = '0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_gain_extremes();
        test_full_scale_extremes();
        test_buffer_full();
        test_backpressure();
        test_random_traffic();

        if (pending_levels.size() != 0) begin
            $error("%0d expected results never arrived", pending_levels.size());
            fail_count = fail_count + 1;
        end
        if (fail_count == 0) begin
            $display("[stereo_rms_level_meter] OK");
        end else begin
            $display("[stereo_rms_level_meter] ERROR");
        end
        $finish;
    end

endmodule
